### rtl/hrd_pkg.sv
// ----------------------------------------------------------------------------
// hrd_pkg: shared types and constants of the HTTP response deframer
// Holds the parser state encodings, the status codes of a result beat and
// the key text that announces the body length.
// ----------------------------------------------------------------------------
package hrd_pkg;

    // Framing phase of the response.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    // Progress through the CR LF CR LF sequence.
    typedef enum logic [1:0] {
        LE_OTHER  = 2'd0,
        LE_CR     = 2'd1,
        LE_CRLF   = 2'd2,
        LE_CRLFCR = 2'd3
    } t_line_end;

    // Progress of the length value extraction.
    typedef enum logic [1:0] {
        LP_SEARCH  = 2'd0,
        LP_WAIT    = 2'd1,
        LP_VALUE   = 2'd2,
        LP_INVALID = 2'd3
    } t_len_phase;

    // Status code of one result beat.
    typedef enum logic [2:0] {
        ST_HEADER      = 3'd0,
        ST_BODY        = 3'd1,
        ST_BAD_EOL     = 3'd2,
        ST_LEN_MISSING = 3'd3,
        ST_LEN_INVALID = 3'd4,
        ST_IGNORED     = 3'd5
    } t_status;

    // Tokenizer state that travels between the framer and the token scanner.
    typedef struct packed {
        logic [3:0] match_pos;
        logic       mismatch;
        logic       in_token;
        t_len_phase len_phase;
    } t_tok_state;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [3:0] KEY_LEN    = 4'd15;

    // Characters of the key token "Content-Length:".
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h4C; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            4'd14:   ch = 8'h3A; // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### rtl/hrd_token_scan.sv
// ----------------------------------------------------------------------------
// hrd_token_scan: header token scanner
// Splits header bytes into white-space delimited tokens, matches the key
// token and accumulates the decimal digits of the token that follows it.
// ----------------------------------------------------------------------------
module hrd_token_scan #(
    parameter int LENGTH_BITS = 31
) (
    input  hrd_pkg::t_tok_state     i_tok,
    input  logic [LENGTH_BITS-1:0]  i_accum,
    input  logic [7:0]              i_byte,
    output hrd_pkg::t_tok_state     o_tok,
    output logic [LENGTH_BITS-1:0]  o_accum
);
    import hrd_pkg::*;

    localparam int WIDE_BITS = LENGTH_BITS + 4;

    logic                   is_space;
    logic                   is_digit;
    logic [3:0]             pos_eff;
    logic                   mis_eff;
    logic [WIDE_BITS-1:0]   acc_wide;
    logic [WIDE_BITS-1:0]   acc_next;
    logic                   overflow;

    // Character classes.
    assign is_space = (i_byte == 8'h20) || (i_byte == 8'h09) || (i_byte == CHAR_LF) ||
                      (i_byte == 8'h0B) || (i_byte == 8'h0C) || (i_byte == CHAR_CR);
    assign is_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);

    // A new token restarts the key comparison.
    assign pos_eff = i_tok.in_token ? i_tok.match_pos : 4'd0;
    assign mis_eff = i_tok.in_token ? i_tok.mismatch : 1'b0;

    // Times ten plus the digit; the top four bits flag a value past the limit.
    assign acc_wide = {4'b0000, i_accum};
    assign acc_next = (acc_wide << 3) + (acc_wide << 1) +
                      {{(WIDE_BITS-4){1'b0}}, i_byte[3:0]};
    assign overflow = |acc_next[WIDE_BITS-1:LENGTH_BITS];

    // Next tokenizer state for this byte.
    always_comb begin
        o_tok   = i_tok;
        o_accum = i_accum;
        if (is_space) begin
            if (i_tok.len_phase == LP_SEARCH && i_tok.in_token && !i_tok.mismatch &&
                i_tok.match_pos == KEY_LEN) begin
                o_tok.len_phase = LP_WAIT;
            end
            if (i_tok.len_phase == LP_VALUE) begin
                o_tok.mismatch = 1'b1;
            end
            o_tok.in_token = 1'b0;
        end else begin
            unique case (i_tok.len_phase)
                LP_SEARCH: begin
                    if (pos_eff < KEY_LEN && i_byte == key_char(pos_eff)) begin
                        o_tok.match_pos = pos_eff + 4'd1;
                        o_tok.mismatch  = mis_eff;
                    end else begin
                        o_tok.match_pos = pos_eff;
                        o_tok.mismatch  = 1'b1;
                    end
                end
                LP_WAIT: begin
                    if (is_digit) begin
                        o_accum         = {{(LENGTH_BITS-4){1'b0}}, i_byte[3:0]};
                        o_tok.mismatch  = 1'b0;
                        o_tok.len_phase = LP_VALUE;
                    end else begin
                        o_tok.len_phase = LP_INVALID;
                    end
                end
                LP_VALUE: begin
                    if (!i_tok.mismatch) begin
                        if (is_digit) begin
                            if (overflow) begin
                                o_tok.len_phase = LP_INVALID;
                            end else begin
                                o_accum = acc_next[LENGTH_BITS-1:0];
                            end
                        end else begin
                            o_tok.mismatch = 1'b1;
                        end
                    end
                end
                default: begin
                    o_tok.len_phase = LP_INVALID;
                end
            endcase
            o_tok.in_token = 1'b1;
        end
    end

endmodule

### rtl/hrd_frame.sv
// ----------------------------------------------------------------------------
// hrd_frame: response framing state
// Holds the parser state, tracks line endings, reports the header end and
// counts the body bytes down to the last one.
// ----------------------------------------------------------------------------
module hrd_frame #(
    parameter int LENGTH_BITS = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [7:0]              i_byte,
    input  logic                    i_start,
    output hrd_pkg::t_status        o_status,
    output logic [7:0]              o_body_byte,
    output logic                    o_last_body,
    output logic                    o_header_end,
    output logic [LENGTH_BITS-1:0]  o_length
);
    import hrd_pkg::*;

    t_phase                 r_phase,     n_phase,     cur_phase;
    t_line_end              r_line_end,  n_line_end,  cur_line_end;
    t_tok_state             r_tok,       n_tok,       cur_tok,   scan_tok;
    logic [LENGTH_BITS-1:0] r_accum,     n_accum,     cur_accum, scan_accum;
    logic [LENGTH_BITS-1:0] r_remaining, n_remaining, cur_remaining;
    logic                   bad_eol;
    logic                   ended;
    logic [LENGTH_BITS-1:0] rem_dec;

    // A start request puts the state back to its reset values first.
    always_comb begin
        if (i_start) begin
            cur_phase     = PH_HEADER;
            cur_line_end  = LE_OTHER;
            cur_tok       = '{match_pos: 4'd0, mismatch: 1'b0, in_token: 1'b0,
                              len_phase: LP_SEARCH};
            cur_accum     = '0;
            cur_remaining = '0;
        end else begin
            cur_phase     = r_phase;
            cur_line_end  = r_line_end;
            cur_tok       = r_tok;
            cur_accum     = r_accum;
            cur_remaining = r_remaining;
        end
    end

    hrd_token_scan #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_scan (
        .i_tok   (cur_tok),
        .i_accum (cur_accum),
        .i_byte  (i_byte),
        .o_tok   (scan_tok),
        .o_accum (scan_accum)
    );

    assign rem_dec = (cur_remaining != '0) ? cur_remaining - 1'b1 : cur_remaining;

    // Next state and the result for the byte at hand.
    always_comb begin
        n_phase      = cur_phase;
        n_line_end   = cur_line_end;
        n_tok        = cur_tok;
        n_accum      = cur_accum;
        n_remaining  = cur_remaining;
        o_status     = ST_IGNORED;
        o_body_byte  = 8'h00;
        o_last_body  = 1'b0;
        o_header_end = 1'b0;
        o_length     = '0;
        bad_eol      = 1'b0;
        ended        = 1'b0;
        unique case (cur_phase)
            PH_HEADER: begin
                o_status = ST_HEADER;
                n_tok    = scan_tok;
                n_accum  = scan_accum;
                // Line ending tracking.
                if (i_byte == CHAR_CR) begin
                    if (cur_line_end == LE_OTHER) begin
                        n_line_end = LE_CR;
                    end else if (cur_line_end == LE_CRLF) begin
                        n_line_end = LE_CRLFCR;
                    end else begin
                        bad_eol = 1'b1;
                    end
                end else if (i_byte == CHAR_LF) begin
                    if (cur_line_end == LE_CR) begin
                        n_line_end = LE_CRLF;
                    end else if (cur_line_end == LE_CRLFCR) begin
                        ended = 1'b1;
                    end else begin
                        bad_eol = 1'b1;
                    end
                end else begin
                    n_line_end = LE_OTHER;
                end
                // Header end or error.
                if (bad_eol) begin
                    o_status = ST_BAD_EOL;
                    n_phase  = PH_DONE;
                end else if (ended) begin
                    o_header_end = 1'b1;
                    if (scan_tok.len_phase == LP_VALUE) begin
                        o_length    = scan_accum;
                        n_remaining = scan_accum;
                        n_phase     = (scan_accum == '0) ? PH_DONE : PH_BODY;
                    end else begin
                        o_status = (scan_tok.len_phase == LP_INVALID) ?
                                   ST_LEN_INVALID : ST_LEN_MISSING;
                        n_phase  = PH_DONE;
                    end
                end
            end
            PH_BODY: begin
                o_status    = ST_BODY;
                o_body_byte = i_byte;
                n_remaining = rem_dec;
                if (rem_dec == '0) begin
                    o_last_body = 1'b1;
                    n_phase     = PH_DONE;
                end
            end
            default: begin
                o_status = ST_IGNORED;
            end
        endcase
    end

    // State registers advance once per byte handed to the result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_line_end  <= LE_OTHER;
            r_tok       <= '{match_pos: 4'd0, mismatch: 1'b0, in_token: 1'b0,
                             len_phase: LP_SEARCH};
            r_accum     <= '0;
            r_remaining <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_line_end  <= n_line_end;
            r_tok       <= n_tok;
            r_accum     <= n_accum;
            r_remaining <= n_remaining;
        end
    end

endmodule

### rtl/http_response_deframer.sv
// ----------------------------------------------------------------------------
// http_response_deframer: HTTP response header parser and body framer
// Input channel (i_in_valid / o_in_ready) carries one response byte per
// beat with a start flag that restarts the parser on that byte. Output
// channel (o_out_valid / i_out_ready) gives one result beat per input beat:
// a status code, the body byte, a last-body mark, a header-end mark and the
// parsed Content-Length value on the header-end beat.
// Each beat passes the input register, then the result register. Throughput
// is one byte per cycle while the receiver takes every result beat; the
// per-byte state update (token scan, line-end check, body count) sits in
// the single stage between the two registers.
// Reset clears both registers' valid flags and returns the parser to the
// header phase. When the receiver stalls, the result register holds its
// beat, the input register fills, and o_in_ready drops until the result
// beat is taken.
// ----------------------------------------------------------------------------
module http_response_deframer #(
    parameter int LENGTH_BITS = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [7:0]              i_rx_byte,
    input  logic                    i_start_req,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output hrd_pkg::t_status        o_status,
    output logic [7:0]              o_body_byte,
    output logic                    o_last_body,
    output logic                    o_header_end,
    output logic [LENGTH_BITS-1:0]  o_length_out
);
    import hrd_pkg::*;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_start;
    logic                   r_out_valid;
    t_status                r_status;
    logic [7:0]             r_body_byte;
    logic                   r_last_body;
    logic                   r_header_end;
    logic [LENGTH_BITS-1:0] r_length;
    logic                   step;
    t_status                f_status;
    logic [7:0]             f_body_byte;
    logic                   f_last_body;
    logic                   f_header_end;
    logic [LENGTH_BITS-1:0] f_length;

    // The held byte moves on whenever the result register is free or drains.
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    hrd_frame #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .i_start      (r_in_start),
        .o_status     (f_status),
        .o_body_byte  (f_body_byte),
        .o_last_body  (f_last_body),
        .o_header_end (f_header_end),
        .o_length     (f_length)
    );

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte  <= i_rx_byte;
            r_in_start <= i_start_req;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_status     <= f_status;
            r_body_byte  <= f_body_byte;
            r_last_body  <= f_last_body;
            r_header_end <= f_header_end;
            r_length     <= f_length;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_body_byte  = r_body_byte;
    assign o_last_body  = r_last_body;
    assign o_header_end = r_header_end;
    assign o_length_out = r_length;

endmodule

### rtl/hrd_checker.sv
// ----------------------------------------------------------------------------
// hrd_checker: port-level checks of the HTTP response deframer
// Watches the result channel for consistency between the status code and
// the other result fields, and for a stable beat under backpressure.
// ----------------------------------------------------------------------------
module hrd_checker #(
    parameter int LENGTH_BITS = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  hrd_pkg::t_status        o_status,
    input  logic [7:0]              o_body_byte,
    input  logic                    o_last_body,
    input  logic                    o_header_end,
    input  logic [LENGTH_BITS-1:0]  o_length_out
);
    import hrd_pkg::*;

    // A stalled result beat stays valid, with status, body byte and length unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_body_byte) &&
            $stable(o_length_out))
        else $error("result beat changed while stalled");

    // Body data and the last mark appear only on body beats.
    a_body_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_BODY |-> o_body_byte == 8'h00 && !o_last_body)
        else $error("body fields set on a non-body beat");

    // The header end carries a header, missing-length or invalid-length status.
    a_hend_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_header_end |->
            o_status == ST_HEADER || o_status == ST_LEN_MISSING ||
            o_status == ST_LEN_INVALID)
        else $error("header end with an unexpected status");

    // A length is reported only on a clean header end.
    a_length_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_length_out != '0 |-> o_header_end && o_status == ST_HEADER)
        else $error("length reported outside a clean header end");

endmodule

bind http_response_deframer hrd_checker #(
    .LENGTH_BITS (LENGTH_BITS)
) u_hrd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_status     (o_status),
    .o_body_byte  (o_body_byte),
    .o_last_body  (o_last_body),
    .o_header_end (o_header_end),
    .o_length_out (o_length_out)
);

### test/tb_http_response_deframer.sv
// ----------------------------------------------------------------------------
// tb_http_response_deframer: self-checking bench for the response deframer
// Feeds short HTTP responses, broken headers and noise one byte per beat.
// A behavioral parser predicts every result beat, and the results are
// compared field by field, in order, under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_http_response_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import hrd_pkg::*;

    localparam int LEN_W = 31;
    localparam longint unsigned LEN_MAX = (64'd1 << LEN_W) - 1;
    localparam logic [8*15-1:0] LEN_KEY = "Content-Length:";
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    // Expected content of one result beat.
    typedef struct packed {
        t_status          status;
        logic [7:0]       body;
        logic             last;
        logic             hend;
        logic [LEN_W-1:0] len;
    } t_beat_exp;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [7:0]       i_rx_byte;
    logic             i_start_req;
    logic             o_out_valid;
    logic             i_out_ready;
    t_status          o_status;
    logic [7:0]       o_body_byte;
    logic             o_last_body;
    logic             o_header_end;
    logic [LEN_W-1:0] o_length_out;

    http_response_deframer #(
        .LENGTH_BITS(LEN_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (i_rx_byte),
        .i_start_req (i_start_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_body_byte (o_body_byte),
        .o_last_body (o_last_body),
        .o_header_end(o_header_end),
        .o_length_out(o_length_out)
    );

    // Parser state mirrored by the predictor.
    t_phase          frame_ph;
    t_line_end       eol_st;
    int unsigned     key_pos;
    logic            tok_bad;
    logic            tok_open;
    t_len_phase      len_ph;
    longint unsigned len_acc;
    longint unsigned body_left;

    t_beat_exp  expected_beats[$];
    logic [7:0] frame_q[$];
    int         src_idle_pct;
    int         snk_idle_pct;
    int         beats_sent;
    int         beats_checked;
    int         fail_count;
    int         stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_parser();
        frame_ph  = PH_HEADER;
        eol_st    = LE_OTHER;
        key_pos   = 0;
        tok_bad   = 1'b0;
        tok_open  = 1'b0;
        len_ph    = LP_SEARCH;
        len_acc   = 0;
        body_left = 0;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
               c == 8'h0C || c == 8'h0D;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Token scanner: looks for the key token, then takes the leading digits
    // of the token that follows it.
    function automatic void scan_char(input logic [7:0] c);
        longint unsigned grown;
        if (is_blank(c)) begin
            if (len_ph == LP_SEARCH && tok_open && !tok_bad && key_pos == KEY_LEN)
                len_ph = LP_WAIT;
            if (len_ph == LP_VALUE)
                tok_bad = 1'b1;
            tok_open = 1'b0;
            return;
        end
        case (len_ph)
            LP_SEARCH: begin
                if (!tok_open) begin
                    key_pos = 0;
                    tok_bad = 1'b0;
                end
                if (key_pos < KEY_LEN && c == LEN_KEY[8*(int'(KEY_LEN)-1-key_pos) +: 8])
                    key_pos++;
                else
                    tok_bad = 1'b1;
            end
            LP_WAIT: begin
                if (is_digit(c)) begin
                    len_acc = c - 8'h30;
                    tok_bad = 1'b0;
                    len_ph  = LP_VALUE;
                end else begin
                    len_ph = LP_INVALID;
                end
            end
            LP_VALUE: begin
                // Digits after the first non-digit of the value are ignored.
                if (!tok_bad) begin
                    if (is_digit(c)) begin
                        grown = len_acc * 10 + (c - 8'h30);
                        if (grown > LEN_MAX)
                            len_ph = LP_INVALID;
                        else
                            len_acc = grown;
                    end else begin
                        tok_bad = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        tok_open = 1'b1;
    endfunction

    // Works out the result beat of one input beat and advances the state.
    function automatic t_beat_exp predict_beat(input logic [7:0] c, input logic restart);
        t_beat_exp r;
        logic      bad;
        logic      ended;
        r = '0;
        r.status = ST_IGNORED;
        bad = 1'b0;
        ended = 1'b0;
        if (restart)
            clear_parser();
        case (frame_ph)
            PH_HEADER: begin
                r.status = ST_HEADER;
                scan_char(c);
                if (c == CHAR_CR) begin
                    if (eol_st == LE_OTHER)
                        eol_st = LE_CR;
                    else if (eol_st == LE_CRLF)
                        eol_st = LE_CRLFCR;
                    else
                        bad = 1'b1;
                end else if (c == CHAR_LF) begin
                    if (eol_st == LE_CR)
                        eol_st = LE_CRLF;
                    else if (eol_st == LE_CRLFCR)
                        ended = 1'b1;
                    else
                        bad = 1'b1;
                end else begin
                    eol_st = LE_OTHER;
                end
                if (bad) begin
                    r.status = ST_BAD_EOL;
                    frame_ph = PH_DONE;
                end else if (ended) begin
                    r.hend = 1'b1;
                    if (len_ph == LP_VALUE) begin
                        r.len     = len_acc[LEN_W-1:0];
                        body_left = len_acc;
                        frame_ph  = (len_acc == 0) ? PH_DONE : PH_BODY;
                    end else begin
                        r.status = (len_ph == LP_INVALID) ? ST_LEN_INVALID : ST_LEN_MISSING;
                        frame_ph = PH_DONE;
                    end
                end
            end
            PH_BODY: begin
                r.status = ST_BODY;
                r.body   = c;
                if (body_left > 0)
                    body_left--;
                if (body_left == 0) begin
                    r.last   = 1'b1;
                    frame_ph = PH_DONE;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking, receiver stalls and the stall watchdog
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("MISMATCH beat %0d %s: expected %0d, got %0d",
                 beats_checked, what, want, got);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_beat_exp want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected result beat", 0, o_status);
                end else begin
                    want = expected_beats.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", want.status, o_status);
                    if (o_body_byte !== want.body)
                        report_mismatch("body_byte", want.body, o_body_byte);
                    if (o_last_body !== want.last)
                        report_mismatch("last_body", want.last, o_last_body);
                    if (o_header_end !== want.hend)
                        report_mismatch("header_end", want.hend, o_header_end);
                    if (o_length_out !== want.len)
                        report_mismatch("length_out", want.len, o_length_out);
                end
                beats_checked++;
            end
            i_out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Ends the run when neither channel moves a beat for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sends one byte beat, with a random idle gap before it.
    task automatic send_beat(input logic [7:0] c, input logic restart);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_rx_byte   <= c;
        i_start_req <= restart;
        do @(posedge i_clk); while (!o_in_ready);
        expected_beats.push_back(predict_beat(c, restart));
        beats_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            frame_q.push_back(s[i]);
    endtask

    // Sends the queued bytes as one response: the first byte restarts the parser.
    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_beat(frame_q[i], i == 0);
        frame_q.delete();
    endtask

    // Holds the sender until every expected result beat has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_beats.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Well-formed responses: body extremes, zero length, junk after digits, a value on the next line.
    task automatic test_body_framing();
        push_text("Content-Length: 3\r\n\r\n");
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hFF);
        frame_q.push_back(8'h5A);
        push_text("Z");
        send_frame();
        push_text("Content-Length: 0\r\n\r\nQ");
        send_frame();
        push_text("Content-Length:\t12ab34 99\r\n\r\n0123456789AB!");
        send_frame();
        push_text("Host: x Content-Length:\r\n 2\r\n\r\nhi");
        send_frame();
    endtask

    // Bare LF and CR in the wrong place.
    task automatic test_line_endings();
        push_text("\nA");
        send_frame();
        push_text("ab\r\rc");
        send_frame();
        push_text("x\r\n\n");
        send_frame();
        push_text("\r\n\r\r");
        send_frame();
    endtask

    // Missing, signed, oversized and mistyped length values.
    task automatic test_length_faults();
        push_text("\r\n\r\n");
        send_frame();
        push_text("Content-Length:\r\n\r\n");
        send_frame();
        push_text("Content-Length: -5\r\n\r\n");
        send_frame();
        push_text("Content-Length: +7\r\n\r\n");
        send_frame();
        push_text("Content-Length: 2147483648\r\n\r\n");
        send_frame();
        push_text("Content-length: 5\r\n\r\n");
        send_frame();
        push_text("Content-Length:5\r\n\r\n");
        send_frame();
        // Largest length: a few body beats, then the next response restarts.
        push_text("Content-Length: 2147483647\r\n\r\nabc");
        send_frame();
    endtask

    // Restart in the middle of a header and of a body.
    task automatic test_restart();
        push_text("Content-Le");
        send_frame();
        push_text("Content-Length: 4\r\n\r\nab");
        send_frame();
        push_text("Content-Length: 1\r\n\r\nk");
        send_frame();
    endtask

    // ------------------------------------------------------------------
    // Random responses
    // ------------------------------------------------------------------

    task automatic push_filler_line();
        int n_tok;
        int n_chr;
        n_tok = $urandom_range(1, 3);
        for (int t = 0; t < n_tok; t++) begin
            if (t > 0)
                frame_q.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
            n_chr = $urandom_range(1, 6);
            for (int k = 0; k < n_chr; k++) begin
                if ($urandom_range(0, 15) == 0)
                    frame_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
                else
                    frame_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
            end
        end
        push_text("\r\n");
    endtask

    // One header line that carries (or nearly carries) the length, or a filler line.
    task automatic push_length_line(input int form, input int unsigned len);
        longint unsigned big;
        case (form)
            5:  push_text($sformatf("Content-Length:\t\v %0d\r\n", len));
            6:  push_text($sformatf("Content-Length: %0dx7 12\r\n", len));
            7:  push_text($sformatf("Content-Length: 00%0d\r\n", len));
            8:  push_text($sformatf("Content-Length:\r\n %0d\r\n", len));
            9:  push_text($sformatf("Content-Length: %s%0d\r\n",
                                    $urandom_range(0, 1) ? "-" : "+", len));
            10: begin
                big = 64'd2147483647 + $urandom_range(0, 3);
                if ($urandom_range(0, 3) == 0)
                    push_text("Content-Length: 99999999999\r\n");
                else
                    push_text($sformatf("Content-Length: %0d\r\n", big));
            end
            11: begin
                case ($urandom_range(0, 3))
                    0: push_text($sformatf("Content-length: %0d\r\n", len));
                    1: push_text($sformatf("Content-Length:%0d\r\n", len));
                    2: push_text($sformatf("XContent-Length: %0d\r\n", len));
                    default: push_text($sformatf("Content-Lengt: %0d\r\n", len));
                endcase
            end
            12: push_text($sformatf("Content-Length: %0d Content-Length: 9\r\n", len));
            13: push_filler_line();
            default: push_text($sformatf("Content-Length: %0d\r\n", len));
        endcase
    endtask

    // Mostly well-formed responses with random content; some are corrupted,
    // cut short or replaced by raw noise.
    task automatic send_random_response();
        int unsigned len;
        int          n_lines;
        int          key_line;
        int          form;
        int          body_n;
        int          cut;
        if ($urandom_range(0, 19) == 0) begin
            body_n = $urandom_range(1, 12);
            for (int i = 0; i < body_n; i++)
                send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            return;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 64) : $urandom_range(0, 20);
        n_lines  = $urandom_range(0, 3);
        key_line = $urandom_range(0, n_lines);
        form     = $urandom_range(0, 13);
        for (int i = 0; i <= n_lines; i++) begin
            if (i == key_line)
                push_length_line(form, len);
            else
                push_filler_line();
        end
        push_text("\r\n");
        if ($urandom_range(0, 9) == 0)
            frame_q.insert($urandom_range(0, frame_q.size() - 1),
                           $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        body_n = (form == 10) ? $urandom_range(1, 8) : len;
        if ($urandom_range(0, 3) == 0)
            body_n += $urandom_range(1, 3);
        for (int i = 0; i < body_n; i++)
            frame_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 19) == 0) begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut)
                void'(frame_q.pop_back());
        end
        send_frame();
    endtask

    task automatic test_random_responses(input int src_pct, input int snk_pct,
                                         input int n_beats);
        int stop_at;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            send_random_response();
            if ($urandom_range(0, 14) == 0)
                drain_results();
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_rx_byte     = 8'h00;
        i_start_req   = 1'b0;
        i_out_ready   = 1'b0;
        src_idle_pct  = 21;
        snk_idle_pct  = 65;
        beats_sent    = 0;
        beats_checked = 0;
        fail_count    = 0;
        stall_cycles  = 0;
        clear_parser();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_body_framing();
        test_line_endings();
        test_length_faults();
        test_restart();
        drain_results();

        test_random_responses(21, 65, 500);
        test_random_responses(65, 21, 500);
        test_random_responses(0, 0, 500);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/hrd_pkg.sv
rtl/hrd_token_scan.sv
rtl/hrd_frame.sv
rtl/http_response_deframer.sv
rtl/hrd_checker.sv
test/tb_http_response_deframer.sv
